[design/i2p_pkg.sv]
// shared types, codes and constants for the infix to postfix reorder core
// no dependencies

package i2p_pkg;

    localparam int STACK_DEPTH = 32;
    localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
    localparam int ADDR_W      = $clog2(STACK_DEPTH);

    localparam logic [7:0] OPEN_CH = 8'h28;

    // input token kinds
    localparam logic [2:0] TK_NUMBER  = 3'd0;
    localparam logic [2:0] TK_OPER    = 3'd1;
    localparam logic [2:0] TK_OPEN    = 3'd2;
    localparam logic [2:0] TK_CLOSE   = 3'd3;
    localparam logic [2:0] TK_NEWLINE = 3'd4;
    localparam logic [2:0] TK_SPECIAL = 3'd5;

    // result kinds
    localparam logic [1:0] OK_NUMBER = 2'd0;
    localparam logic [1:0] OK_OPER   = 2'd1;
    localparam logic [1:0] OK_END    = 2'd2;

    // status codes
    localparam logic [2:0] SC_OK        = 3'd0;
    localparam logic [2:0] SC_SPECIAL   = 3'd1;
    localparam logic [2:0] SC_UNKNOWN   = 3'd2;
    localparam logic [2:0] SC_UNMATCHED = 3'd3;
    localparam logic [2:0] SC_OVERFLOW  = 3'd4;

    typedef struct packed {
        logic       paren;
        logic [3:0] pri;
        logic [7:0] sign;
    } stack_entry_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] payload;
        logic [7:0]  sign;
        logic [3:0]  pri;
        logic [2:0]  status;
    } result_t;

    typedef struct packed {
        logic    emit;
        logic    finish;
        result_t item;
    } emit_req_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_RD,
        ST_EVAL,
        ST_ERR,
        ST_FRD,
        ST_FEVAL,
        ST_DONE
    } state_t;

endpackage

[design/i2p_stack.sv]
// operator stack memory, one write and one registered read port
// depends on i2p_pkg

module i2p_stack
    import i2p_pkg::*;
(
    input  logic               clk,
    input  logic               we,
    input  logic [ADDR_W-1:0]  waddr,
    input  stack_entry_t       wdata,
    input  logic [ADDR_W-1:0]  raddr,
    output stack_entry_t       rdata
);

    stack_entry_t mem [STACK_DEPTH];
    stack_entry_t rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

[design/i2p_outbuf.sv]
// result staging: one pending item so the end of a run can be marked, then the
// output register toward the master side; depends on i2p_pkg

module i2p_outbuf
    import i2p_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  emit_req_t  req,
    output logic       room,
    output logic       out_valid,
    input  logic       out_ready,
    output result_t    out_item,
    output logic       out_last
);

    logic    pend_valid_reg, pend_valid_next;
    result_t pend_reg, pend_next;
    logic    out_valid_reg, out_valid_next;
    result_t out_reg, out_next;
    logic    out_last_reg, out_last_next;
    logic    load_out;

    assign room     = !pend_valid_reg || !out_valid_reg || out_ready;
    assign load_out = room && pend_valid_reg && (req.emit || req.finish);

    always_comb
    begin
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;
        out_valid_next  = out_valid_reg;
        out_next        = out_reg;
        out_last_next   = out_last_reg;
        if (out_valid_reg && out_ready)
        begin
            out_valid_next = 1'b0;
        end
        if (load_out)
        begin
            out_valid_next = 1'b1;
            out_next       = pend_reg;
            out_last_next  = req.finish;
        end
        if (room && req.emit)
        begin
            pend_valid_next = 1'b1;
            pend_next       = req.item;
        end
        else if (room && req.finish)
        begin
            pend_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            pend_valid_reg <= pend_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg     <= pend_next;
        out_reg      <= out_next;
        out_last_reg <= out_last_next;
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_reg;
    assign out_last  = out_last_reg;

endmodule

[design/i2p_ctrl.sv]
// token sequencer: priority compare, stack pointer and result requests
// depends on i2p_pkg; drives i2p_stack and i2p_outbuf

module i2p_ctrl
    import i2p_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic [2:0]         in_kind,
    input  logic [31:0]        in_payload,
    input  logic [7:0]         in_sign,
    input  logic [3:0]         in_pri,
    input  logic               in_eoe,
    output logic               mem_we,
    output logic [ADDR_W-1:0]  mem_waddr,
    output stack_entry_t       mem_wdata,
    output logic [ADDR_W-1:0]  mem_raddr,
    input  stack_entry_t       top,
    output emit_req_t          req,
    input  logic               room
);

    state_t            state_reg, state_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              discard_reg, discard_next;
    logic [2:0]        err_reg, err_next;
    logic [2:0]        kind_reg;
    logic [31:0]       pay_reg;
    logic [7:0]        sign_reg;
    logic [3:0]        pri_reg;
    logic              eoe_reg;

    logic              top_valid;
    logic              full;
    logic              op_pop;
    logic              cl_pop;
    logic [CNT_W-1:0]  rd_index;
    state_t            after_tok;
    result_t           op_item;

    assign top_valid = count_reg != '0;
    assign full      = count_reg == CNT_W'(STACK_DEPTH);
    assign op_pop    = top_valid && !top.paren && (top.pri >= pri_reg);
    assign cl_pop    = top_valid && !top.paren;
    assign after_tok = eoe_reg ? ST_FRD : ST_DONE;
    assign rd_index  = top_valid ? (count_reg - 1'b1) : '0;
    assign mem_raddr = rd_index[ADDR_W-1:0];
    assign mem_waddr = count_reg[ADDR_W-1:0];
    assign in_ready  = state_reg == ST_IDLE;

    always_comb
    begin
        op_item         = '0;
        op_item.kind    = OK_OPER;
        op_item.sign    = top.sign;
        op_item.pri     = top.pri;
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = ST_RD;
                end
            end
            ST_RD:
            begin
                state_next = ST_EVAL;
            end
            ST_EVAL:
            begin
                if (discard_reg)
                begin
                    state_next = ST_IDLE;
                end
                else
                begin
                    case (kind_reg)
                        TK_NUMBER:
                        begin
                            if (room)
                            begin
                                state_next = after_tok;
                            end
                        end
                        TK_OPER:
                        begin
                            if (op_pop)
                            begin
                                if (room)
                                begin
                                    state_next = ST_RD;
                                end
                            end
                            else if (full)
                            begin
                                state_next = ST_ERR;
                            end
                            else
                            begin
                                state_next = after_tok;
                            end
                        end
                        TK_OPEN:
                        begin
                            state_next = full ? ST_ERR : after_tok;
                        end
                        TK_CLOSE:
                        begin
                            if (cl_pop)
                            begin
                                if (room)
                                begin
                                    state_next = ST_RD;
                                end
                            end
                            else if (!top_valid)
                            begin
                                state_next = ST_ERR;
                            end
                            else
                            begin
                                state_next = after_tok;
                            end
                        end
                        TK_NEWLINE:
                        begin
                            state_next = after_tok;
                        end
                        default:
                        begin
                            state_next = ST_ERR;
                        end
                    endcase
                end
            end
            ST_ERR:
            begin
                if (room)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_FRD:
            begin
                state_next = ST_FEVAL;
            end
            ST_FEVAL:
            begin
                if (top_valid)
                begin
                    if (top.paren || room)
                    begin
                        state_next = ST_FRD;
                    end
                end
                else if (room)
                begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE:
            begin
                if (room)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // outputs and datapath updates
    always_comb
    begin
        count_next   = count_reg;
        discard_next = discard_reg;
        err_next     = err_reg;
        mem_we       = 1'b0;
        mem_wdata    = '0;
        req          = '0;
        case (state_reg)
            ST_EVAL:
            begin
                if (discard_reg)
                begin
                    if (eoe_reg)
                    begin
                        discard_next = 1'b0;
                        count_next   = '0;
                    end
                end
                else
                begin
                    case (kind_reg)
                        TK_NUMBER:
                        begin
                            req.emit         = 1'b1;
                            req.item.kind    = OK_NUMBER;
                            req.item.payload = pay_reg;
                        end
                        TK_OPER:
                        begin
                            if (op_pop)
                            begin
                                req.emit = 1'b1;
                                req.item = op_item;
                                if (room)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                            else if (full)
                            begin
                                err_next = SC_OVERFLOW;
                            end
                            else
                            begin
                                mem_we         = 1'b1;
                                mem_wdata.pri  = pri_reg;
                                mem_wdata.sign = sign_reg;
                                count_next     = count_reg + 1'b1;
                            end
                        end
                        TK_OPEN:
                        begin
                            if (full)
                            begin
                                err_next = SC_OVERFLOW;
                            end
                            else
                            begin
                                mem_we          = 1'b1;
                                mem_wdata.paren = 1'b1;
                                mem_wdata.sign  = OPEN_CH;
                                count_next      = count_reg + 1'b1;
                            end
                        end
                        TK_CLOSE:
                        begin
                            if (cl_pop)
                            begin
                                req.emit = 1'b1;
                                req.item = op_item;
                                if (room)
                                begin
                                    count_next = count_reg - 1'b1;
                                end
                            end
                            else if (!top_valid)
                            begin
                                err_next = SC_UNMATCHED;
                            end
                            else
                            begin
                                count_next = count_reg - 1'b1;
                            end
                        end
                        TK_NEWLINE:
                        begin
                            count_next = count_reg;
                        end
                        TK_SPECIAL:
                        begin
                            err_next = SC_SPECIAL;
                        end
                        default:
                        begin
                            err_next = SC_UNKNOWN;
                        end
                    endcase
                end
            end
            ST_ERR:
            begin
                req.emit        = 1'b1;
                req.item.kind   = OK_END;
                req.item.status = err_reg;
                if (room)
                begin
                    count_next   = '0;
                    discard_next = !eoe_reg;
                end
            end
            ST_FEVAL:
            begin
                if (top_valid)
                begin
                    req.emit = !top.paren;
                    req.item = op_item;
                    if (top.paren || room)
                    begin
                        count_next = count_reg - 1'b1;
                    end
                end
                else
                begin
                    req.emit      = 1'b1;
                    req.item.kind = OK_END;
                end
            end
            ST_DONE:
            begin
                req.finish = 1'b1;
            end
            default:
            begin
                req = '0;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            count_reg   <= '0;
            discard_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            discard_reg <= discard_next;
        end
    end

    always_ff @(posedge clk)
    begin
        err_reg <= err_next;
        if (in_valid && in_ready)
        begin
            kind_reg <= in_kind;
            pay_reg  <= in_payload;
            sign_reg <= in_sign;
            pri_reg  <= in_pri;
            eoe_reg  <= in_eoe;
        end
    end

endmodule

[design/infix_to_postfix_reorder_core.sv]
// Infix to postfix token reorder with an operator stack (shunting-yard).
// Tokens enter on the s_ side one at a time and postfix results leave on the
// m_ side; m_tlast marks the last result caused by a token. The block takes
// one token at a time; each stacked operator popped waits for a registered
// read of the stack memory between one compare and the next. The flush at
// the end of an expression pops each stack entry in turn, then sends the end
// marker; an error result is sent from its own state, and a token swallowed
// while the rest of a broken expression is discarded sends nothing. Output
// back-pressure can stall the steps that send a result. No clearing pass
// follows reset. Depends on i2p_pkg, i2p_ctrl, i2p_stack and i2p_outbuf.

module infix_to_postfix_reorder_core
    import i2p_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // payload, sign_code, priority_req, zero fill
    input  logic [2:0]  s_tuser,   // token_kind
    input  logic        s_tlast,
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // out_payload, out_sign, out_priority, zero fill
    output logic [4:0]  m_tuser,   // out_kind, status
    output logic        m_tlast
);

    logic               mem_we;
    logic [ADDR_W-1:0]  mem_waddr;
    logic [ADDR_W-1:0]  mem_raddr;
    stack_entry_t       mem_wdata;
    stack_entry_t       top;
    emit_req_t          req;
    logic               room;
    result_t            out_item;

    i2p_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (s_tvalid),
        .in_ready   (s_tready),
        .in_kind    (s_tuser),
        .in_payload (s_tdata[31:0]),
        .in_sign    (s_tdata[39:32]),
        .in_pri     (s_tdata[43:40]),
        .in_eoe     (s_tlast),
        .mem_we     (mem_we),
        .mem_waddr  (mem_waddr),
        .mem_wdata  (mem_wdata),
        .mem_raddr  (mem_raddr),
        .top        (top),
        .req        (req),
        .room       (room)
    );

    i2p_stack u_stack (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (top)
    );

    i2p_outbuf u_outbuf (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (req),
        .room      (room),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item),
        .out_last  (m_tlast)
    );

    assign m_tdata = {4'b0, out_item.pri, out_item.sign, out_item.payload};
    assign m_tuser = {out_item.status, out_item.kind};

endmodule

[design/i2p_checker.sv]
// port-level checks for the infix to postfix reorder core, bound to the top
// depends on i2p_pkg and the infix_to_postfix_reorder_core ports

module i2p_checker
    import i2p_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    input  logic        s_tready,
    input  logic        m_tvalid,
    input  logic        m_tready,
    input  logic [47:0] m_tdata,
    input  logic [4:0]  m_tuser,
    input  logic        m_tlast
);

    // stalled item holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("stalled result changed");

    // one token at a time
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("token taken while busy");

    // error results close the run as end markers
    a_err: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[4:2] != SC_OK) |-> m_tlast && (m_tuser[1:0] == OK_END))
        else $error("error result not last");

    // only numbers carry a payload
    a_pay: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser[1:0] != OK_NUMBER) |-> m_tdata[31:0] == 32'd0)
        else $error("payload on non-number");

endmodule

bind infix_to_postfix_reorder_core i2p_checker u_i2p_checker (.*);

[dv/tb_infix_to_postfix_reorder_core.sv]
// testbench for infix_to_postfix_reorder_core: directed and random token streams,
// with results checked in order against a shunting-yard predictor in this file
// depends on i2p_pkg and the infix_to_postfix_reorder_core rtl
`timescale 1ns / 1ps

module tb_infix_to_postfix_reorder_core;
    import i2p_pkg::*;

    localparam logic [2:0] TK_UNKNOWN     = 3'd6;
    localparam logic [2:0] TK_UNKNOWN_ALT = 3'd7;
    localparam logic [7:0] CLOSE_CH       = 8'h29;
    localparam logic [7:0] NEWLINE_CH     = 8'h0A;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] payload;
        logic [7:0]  sign;
        logic [3:0]  pri;
        logic        eoe;
    } token_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [31:0] payload;
        logic [7:0]  sign;
        logic [3:0]  pri;
        logic [2:0]  status;
        logic        last;
    } postfix_item_t;

    logic        clk = 1'b0;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [47:0] s_tdata = '0;   // payload, sign_code, priority_req, zero fill
    logic [2:0]  s_tuser = '0;   // token_kind
    logic        s_tlast = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;        // out_payload, out_sign, out_priority, zero fill
    logic [4:0]  m_tuser;        // out_kind, status
    logic        m_tlast;

    infix_to_postfix_reorder_core dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // predictor state
    stack_entry_t  op_stack [STACK_DEPTH];
    int            op_depth = 0;
    bit            skipping = 1'b0;
    postfix_item_t postfix_q [$];

    int fails = 0;
    int tokens_sent = 0;
    int live_tokens = 0;
    int results_seen = 0;
    int end_markers = 0;
    int error_results = 0;
    int deepest = 0;
    int burst_left = 0;
    bit valid_up = 1'b0;

    function automatic token_t tok(logic [2:0] kind, logic [31:0] payload, logic [7:0] sign,
                                   logic [3:0] pri, logic eoe);
        token_t t;
        t.kind    = kind;
        t.payload = payload;
        t.sign    = sign;
        t.pri     = pri;
        t.eoe     = eoe;
        return t;
    endfunction

    function automatic postfix_item_t make_item(logic [1:0] kind, logic [31:0] payload,
                                                logic [7:0] sign, logic [3:0] pri,
                                                logic [2:0] status);
        postfix_item_t r;
        r.kind    = kind;
        r.payload = payload;
        r.sign    = sign;
        r.pri     = pri;
        r.status  = status;
        r.last    = 1'b0;
        return r;
    endfunction

    task automatic predict_postfix(input token_t t);
        postfix_item_t run [$];
        logic [2:0]    err;
        err = SC_OK;
        if (skipping) begin
            if (t.eoe) begin
                skipping = 1'b0;
                op_depth = 0;
            end
            return;
        end
        case (t.kind)
            TK_NUMBER: run.push_back(make_item(OK_NUMBER, t.payload, '0, '0, SC_OK));
            TK_OPER: begin
                while (op_depth > 0 && !op_stack[op_depth-1].paren &&
                       op_stack[op_depth-1].pri >= t.pri) begin
                    run.push_back(make_item(OK_OPER, '0, op_stack[op_depth-1].sign,
                                            op_stack[op_depth-1].pri, SC_OK));
                    op_depth--;
                end
                if (op_depth >= STACK_DEPTH)
                    err = SC_OVERFLOW;
                else begin
                    op_stack[op_depth] = '{1'b0, t.pri, t.sign};
                    op_depth++;
                end
            end
            TK_OPEN: begin
                if (op_depth >= STACK_DEPTH)
                    err = SC_OVERFLOW;
                else begin
                    op_stack[op_depth] = '{1'b1, 4'd0, OPEN_CH};
                    op_depth++;
                end
            end
            TK_CLOSE: begin
                while (op_depth > 0 && !op_stack[op_depth-1].paren) begin
                    run.push_back(make_item(OK_OPER, '0, op_stack[op_depth-1].sign,
                                            op_stack[op_depth-1].pri, SC_OK));
                    op_depth--;
                end
                if (op_depth == 0)
                    err = SC_UNMATCHED;
                else
                    op_depth--;
            end
            TK_NEWLINE: ;
            TK_SPECIAL: err = SC_SPECIAL;
            default: err = SC_UNKNOWN;
        endcase
        if (op_depth > deepest)
            deepest = op_depth;
        if (err != SC_OK) begin
            run.push_back(make_item(OK_END, '0, '0, '0, err));
            op_depth = 0;
            skipping = !t.eoe;
        end else if (t.eoe) begin
            while (op_depth > 0) begin
                if (!op_stack[op_depth-1].paren)
                    run.push_back(make_item(OK_OPER, '0, op_stack[op_depth-1].sign,
                                            op_stack[op_depth-1].pri, SC_OK));
                op_depth--;
            end
            run.push_back(make_item(OK_END, '0, '0, '0, SC_OK));
        end
        if (run.size() > 0)
            run[run.size()-1].last = 1'b1;
        foreach (run[i])
            postfix_q.push_back(run[i]);
    endtask

    task automatic send_token(input token_t t);
        s_tdata  <= {4'b0, t.pri, t.sign, t.payload};
        s_tuser  <= t.kind;
        s_tlast  <= t.eoe;
        s_tvalid <= 1'b1;
        valid_up = 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        tokens_sent++;
        if (!skipping)
            live_tokens++;
        predict_postfix(t);
        if (burst_left > 0)
            burst_left--;
        else begin
            burst_left = $urandom_range(0, 11);
            if ($urandom_range(0, 4) == 0)
                burst_left = $urandom_range(20, 60);
            else begin
                s_tvalid <= 1'b0;
                valid_up = 1'b0;
                repeat ($urandom_range(1, 7))
                    @(posedge clk);
            end
        end
    endtask

    task automatic drain_results();
        if (valid_up) begin
            s_tvalid <= 1'b0;
            valid_up = 1'b0;
        end
        while (postfix_q.size() != 0)
            @(posedge clk);
    endtask

    // receiver stall pattern
    int rx_mode = 0;
    int mode_left = 0;
    int stall_left = 0;
    int rx_cycle = 0;

    always @(posedge clk)
    begin
        rx_cycle++;
        if (mode_left == 0) begin
            rx_mode   = $urandom_range(0, 3);
            mode_left = $urandom_range(50, 300);
        end else
            mode_left--;
        case (rx_mode)
            0: m_tready <= 1'b1;
            1: m_tready <= 1'($urandom_range(0, 1));
            2: m_tready <= (rx_cycle % 4 == 0);
            default: begin
                if (stall_left > 0) begin
                    m_tready <= 1'b0;
                    stall_left--;
                end else begin
                    m_tready <= 1'b1;
                    if ($urandom_range(0, 5) == 0)
                        stall_left = $urandom_range(1, 12);
                end
            end
        endcase
    end

    function automatic void check_field(string name, longint unsigned want,
                                        longint unsigned got);
        if (want != got) begin
            $error("%s: expected %0h, got %0h", name, want, got);
            fails++;
        end
    endfunction

    postfix_item_t got_item;
    postfix_item_t want_item;

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready) begin
            got_item.payload = m_tdata[31:0];
            got_item.sign    = m_tdata[39:32];
            got_item.pri     = m_tdata[43:40];
            got_item.kind    = m_tuser[1:0];
            got_item.status  = m_tuser[4:2];
            got_item.last    = m_tlast;
            results_seen++;
            if (postfix_q.size() == 0) begin
                $error("result with nothing expected: kind %0d status %0d payload %0h",
                       got_item.kind, got_item.status, got_item.payload);
                fails++;
            end else begin
                want_item = postfix_q.pop_front();
                check_field("out_kind", 64'(want_item.kind), 64'(got_item.kind));
                check_field("out_payload", 64'(want_item.payload), 64'(got_item.payload));
                check_field("out_sign", 64'(want_item.sign), 64'(got_item.sign));
                check_field("out_priority", 64'(want_item.pri), 64'(got_item.pri));
                check_field("status", 64'(want_item.status), 64'(got_item.status));
                check_field("last_of_run", 64'(want_item.last), 64'(got_item.last));
                if (want_item.kind == OK_END && want_item.status == SC_OK)
                    end_markers++;
                if (want_item.status != SC_OK)
                    error_results++;
            end
        end
    end

    task automatic test_basic_expression();
        send_token(tok(TK_NUMBER, 32'h0000_0000, 8'h00, 4'd0, 1'b0));
        send_token(tok(TK_OPER, '0, "*", 4'd15, 1'b0));
        send_token(tok(TK_NUMBER, 32'hFFFF_FFFF, 8'hFF, 4'd15, 1'b0));
        send_token(tok(TK_OPER, '0, "+", 4'd0, 1'b0));
        send_token(tok(TK_OPEN, '0, OPEN_CH, 4'd0, 1'b0));
        send_token(tok(TK_NUMBER, 32'h0000_1234, 8'h00, 4'd0, 1'b0));
        send_token(tok(TK_OPER, '0, 8'hFF, 4'd15, 1'b0));
        send_token(tok(TK_NUMBER, 32'h0000_0005, 8'h00, 4'd0, 1'b0));
        send_token(tok(TK_CLOSE, '0, CLOSE_CH, 4'd0, 1'b0));
        send_token(tok(TK_OPER, '0, 8'h00, 4'd0, 1'b0));
        send_token(tok(TK_NEWLINE, '0, NEWLINE_CH, 4'd0, 1'b0));
        send_token(tok(TK_OPEN, '0, OPEN_CH, 4'd0, 1'b0));
        // flush drops the open paren left on the stack
        send_token(tok(TK_NUMBER, 32'hA5A5_A5A5, 8'h00, 4'd0, 1'b1));
        send_token(tok(TK_NEWLINE, '0, NEWLINE_CH, 4'd0, 1'b1));
        drain_results();
    endtask

    task automatic test_error_cases();
        // unmatched close pops the operator first, then discards to end
        send_token(tok(TK_NUMBER, 32'd7, 8'h00, 4'd0, 1'b0));
        send_token(tok(TK_OPER, '0, "-", 4'd4, 1'b0));
        send_token(tok(TK_CLOSE, '0, CLOSE_CH, 4'd0, 1'b0));
        send_token(tok(TK_NUMBER, 32'd9, 8'h00, 4'd0, 1'b0));
        send_token(tok(TK_OPER, '0, "+", 4'd2, 1'b1));
        send_token(tok(TK_SPECIAL, '0, "$", 4'd0, 1'b1));
        send_token(tok(TK_NUMBER, 32'd1, 8'h00, 4'd0, 1'b0));
        send_token(tok(TK_UNKNOWN, 32'hDEAD_BEEF, 8'h41, 4'd3, 1'b0));
        send_token(tok(TK_NUMBER, 32'd2, 8'h00, 4'd0, 1'b1));
        send_token(tok(TK_UNKNOWN_ALT, '0, 8'h00, 4'd0, 1'b1));
        send_token(tok(TK_CLOSE, '0, CLOSE_CH, 4'd0, 1'b1));
        send_token(tok(TK_SPECIAL, '0, 8'h00, 4'd0, 1'b0));
        send_token(tok(TK_NEWLINE, '0, NEWLINE_CH, 4'd0, 1'b1));
        drain_results();
    endtask

    task automatic test_stack_overflow();
        // operator push onto a full stack
        repeat (STACK_DEPTH - 1)
            send_token(tok(TK_OPEN, '0, OPEN_CH, 4'd0, 1'b0));
        send_token(tok(TK_OPER, '0, "+", 4'd3, 1'b0));
        send_token(tok(TK_OPER, '0, "*", 4'd9, 1'b0));
        send_token(tok(TK_NUMBER, 32'd3, 8'h00, 4'd0, 1'b1));
        drain_results();
        // open paren push onto a full stack, on the final token
        repeat (STACK_DEPTH)
            send_token(tok(TK_OPEN, '0, OPEN_CH, 4'd0, 1'b0));
        send_token(tok(TK_OPEN, '0, OPEN_CH, 4'd0, 1'b1));
        drain_results();
    endtask

    task automatic test_random_expressions(input int target);
        token_t expr [$];
        token_t t;
        int     start;
        int     sel;
        int     nest_cap;
        int     open_odds;
        int     terms;
        int     depth;
        string  signs;
        signs = "+-*/^%";
        start = live_tokens;
        while (live_tokens - start < target) begin
            expr.delete();
            sel = $urandom_range(0, 9);
            if (sel == 0) begin
                // noise
                repeat ($urandom_range(1, 6)) begin
                    t = tok(3'($urandom_range(0, 7)), $urandom(),
                            8'($urandom_range(0, 255)), 4'($urandom_range(0, 15)),
                            $urandom_range(0, 4) == 0);
                    expr.push_back(t);
                end
            end else begin
                if ($urandom_range(0, 12) == 0) begin
                    nest_cap  = $urandom_range(20, 34);
                    open_odds = 3;
                end else begin
                    nest_cap  = $urandom_range(0, 4);
                    open_odds = 1;
                end
                terms = $urandom_range(1, 8);
                depth = 0;
                for (int i = 0; i < terms; i++) begin
                    if (i > 0) begin
                        t = tok(TK_OPER, $urandom(),
                                ($urandom_range(0, 3) == 0) ? 8'($urandom_range(0, 255))
                                    : 8'(signs[$urandom_range(0, 5)]),
                                ($urandom_range(0, 1) == 0) ? 4'($urandom_range(1, 3))
                                    : 4'($urandom_range(0, 15)), 1'b0);
                        expr.push_back(t);
                    end
                    while (depth < nest_cap && $urandom_range(0, 3) < open_odds) begin
                        expr.push_back(tok(TK_OPEN, $urandom(), OPEN_CH, 4'd0, 1'b0));
                        depth++;
                    end
                    if ($urandom_range(0, 7) == 0)
                        expr.push_back(tok(TK_NEWLINE, '0, NEWLINE_CH, 4'd0, 1'b0));
                    expr.push_back(tok(TK_NUMBER, $urandom(), 8'($urandom_range(0, 255)),
                                       4'($urandom_range(0, 15)), 1'b0));
                    while (depth > 0 && $urandom_range(0, 2) == 0) begin
                        expr.push_back(tok(TK_CLOSE, $urandom(), CLOSE_CH, 4'd0, 1'b0));
                        depth--;
                    end
                end
                if ($urandom_range(0, 3) != 0) begin
                    while (depth > 0) begin
                        expr.push_back(tok(TK_CLOSE, '0, CLOSE_CH, 4'd0, 1'b0));
                        depth--;
                    end
                end
                if ($urandom_range(0, 5) == 0)
                    expr.push_back(tok(TK_NEWLINE, '0, NEWLINE_CH, 4'd0, 1'b0));
                expr[expr.size()-1].eoe = 1'b1;
                // broken expression: one bad token inserted
                if (sel == 1) begin
                    t = expr[$urandom_range(0, expr.size() - 1)];
                    case ($urandom_range(0, 3))
                        0: t.kind = TK_CLOSE;
                        1: t.kind = TK_SPECIAL;
                        2: t.kind = TK_UNKNOWN;
                        default: t.kind = TK_UNKNOWN_ALT;
                    endcase
                    expr.insert($urandom_range(0, expr.size() - 1), t);
                end
            end
            foreach (expr[i])
                send_token(expr[i]);
            if ($urandom_range(0, 11) == 0)
                drain_results();
        end
        drain_results();
    endtask

    initial
    begin
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_basic_expression();
        test_error_cases();
        test_stack_overflow();
        test_random_expressions(270);
        repeat (200)
            @(posedge clk);
        if (postfix_q.size() != 0) begin
            $error("%0d expected results never arrived", postfix_q.size());
            fails++;
        end
        $display("run covered %0d tokens (%0d acted on) and %0d results", tokens_sent,
                 live_tokens, results_seen);
        $display("%0d end markers, %0d error results, deepest operator stack %0d",
                 end_markers, error_results, deepest);
        if (fails == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("timeout with %0d results outstanding", postfix_q.size());
        $display("*** FAILED ***");
        $finish;
    end

endmodule

[files.f]
design/i2p_pkg.sv
design/i2p_stack.sv
design/i2p_outbuf.sv
design/i2p_ctrl.sv
design/infix_to_postfix_reorder_core.sv
design/i2p_checker.sv
dv/tb_infix_to_postfix_reorder_core.sv
